// ===== rtl/core/ampq_pkg.sv =====
package ampq_pkg;

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 9;

	typedef logic [1:0] action_t;

	localparam action_t ACT_INSERT = 2'd0;
	localparam action_t ACT_REMOVE = 2'd1;
	localparam action_t ACT_READ   = 2'd2;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_FINISH
	} seq_state_t;

	typedef struct packed {
		logic en;
		logic first;
	} scan_ctl_t;

endpackage

// ===== rtl/core/ampq_if.sv =====
interface ampq_req_if;
	import ampq_pkg::*;

	logic                       valid;
	logic                       ready;
	action_t                    action;
	logic signed [VALUE_W-1:0]  value;

	modport source (output valid, action, value, input ready);
	modport sink   (input valid, action, value, output ready);
endinterface

interface ampq_rsp_if;
	import ampq_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [VALUE_W-1:0]  result_value;
	logic [1:0]                 status;
	logic [COUNT_W-1:0]         count;

	modport source (output valid, result_value, status, count, input ready);
	modport sink   (input valid, result_value, status, count, output ready);
endinterface

// ===== rtl/core/ampq_mem.sv =====
module ampq_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [AW-1:0]                   waddr,
	input  logic [ampq_pkg::VALUE_W-1:0]    wdata,
	input  logic                            re,
	input  logic [AW-1:0]                   raddr,
	output logic [ampq_pkg::VALUE_W-1:0]    rdata
);
	import ampq_pkg::*;

	logic [VALUE_W-1:0] mem [DEPTH];
	logic [VALUE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/ampq_scan.sv =====
module ampq_scan #(
	parameter int AW = 8
) (
	input  logic                                clk,
	input  ampq_pkg::scan_ctl_t                 ctl,
	input  logic [ampq_pkg::VALUE_W-1:0]        data,
	input  logic [AW-1:0]                       idx,
	output logic signed [ampq_pkg::VALUE_W-1:0] best_val,
	output logic [AW-1:0]                       best_idx
);
	import ampq_pkg::*;

	logic signed [VALUE_W-1:0] best_val_q;
	logic [AW-1:0]             best_idx_q;
	logic                      take;

	// strict greater keeps the earliest entry on ties
	assign take     = ctl.first || ($signed(data) > best_val_q);
	assign best_val = take ? $signed(data) : best_val_q;
	assign best_idx = take ? idx : best_idx_q;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			best_val_q <= best_val;
			best_idx_q <= best_idx;
		end
	end

endmodule

// ===== rtl/core/ampq_ctrl.sv =====
module ampq_ctrl #(
	parameter int CAPACITY = 256,
	parameter int AW       = 8,
	parameter int CW       = 9
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  ampq_pkg::action_t                   req_action,
	input  logic signed [ampq_pkg::VALUE_W-1:0] req_value,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic signed [ampq_pkg::VALUE_W-1:0] res_value,
	output ampq_pkg::status_t                   res_status,
	output logic [CW-1:0]                       res_count,
	output logic                                mem_we,
	output logic [AW-1:0]                       mem_waddr,
	output logic [ampq_pkg::VALUE_W-1:0]        mem_wdata,
	output logic                                mem_re,
	output logic [AW-1:0]                       mem_raddr,
	input  logic [ampq_pkg::VALUE_W-1:0]        mem_rdata,
	output ampq_pkg::scan_ctl_t                 scan_ctl,
	output logic [AW-1:0]                       scan_idx,
	input  logic signed [ampq_pkg::VALUE_W-1:0] scan_best_val,
	input  logic [AW-1:0]                       scan_best_idx
);
	import ampq_pkg::*;

	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);
	localparam logic [CW-1:0] TWO_C = CW'(2);

	seq_state_t                 state_q, state_d;
	logic [CW-1:0]              cnt_q, cnt_d;
	logic [CW-1:0]              ra_q, ra_d;
	logic [AW-1:0]              w_q, w_d;
	action_t                    act_q, act_d;
	logic signed [VALUE_W-1:0]  val_q, val_d;
	status_t                    st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		ra_q  <= ra_d;
		w_q   <= w_d;
		act_q <= act_d;
		val_q <= val_d;
		st_q  <= st_d;
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		ra_d      = ra_q;
		w_d       = w_q;
		act_d     = act_q;
		val_d     = val_q;
		st_d      = st_q;
		req_ready = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = w_q;
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = ra_q[AW-1:0];
		scan_ctl  = '{en: 1'b0, first: 1'b0};
		scan_idx  = AW'(ra_q - ONE_C);

		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					act_d   = req_action;
					val_d   = '0;
					st_d    = ST_OK;
					state_d = S_FINISH;
					case (req_action)
						ACT_INSERT: begin
							if (cnt_q == CAP_C) begin
								st_d = ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = cnt_q[AW-1:0];
								mem_wdata = req_value;
								cnt_d     = cnt_q + ONE_C;
							end
						end
						ACT_REMOVE, ACT_READ: begin
							if (cnt_q == '0) begin
								st_d = ST_EMPTY;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = '0;
								ra_d      = ONE_C;
								state_d   = S_SCAN;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				scan_ctl = '{en: 1'b1, first: (ra_q == ONE_C)};
				if (ra_q == cnt_q) begin
					val_d = scan_best_val;
					if (act_q == ACT_READ) begin
						state_d = S_FINISH;
					end else if (CW'(scan_best_idx) + ONE_C == cnt_q) begin
						cnt_d   = cnt_q - ONE_C;
						state_d = S_FINISH;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = scan_best_idx + AW'(1);
						w_d       = scan_best_idx;
						state_d   = S_SHIFT;
					end
				end else begin
					mem_re    = 1'b1;
					mem_raddr = ra_q[AW-1:0];
					ra_d      = ra_q + ONE_C;
				end
			end
			S_SHIFT: begin
				mem_we    = 1'b1;
				mem_waddr = w_q;
				mem_wdata = mem_rdata;
				if (CW'(w_q) + TWO_C == cnt_q) begin
					cnt_d   = cnt_q - ONE_C;
					state_d = S_FINISH;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = w_q + AW'(2);
					w_d       = w_q + AW'(1);
				end
			end
			S_FINISH: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign res_value  = val_q;
	assign res_status = st_q;
	assign res_count  = cnt_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP_C)
		else $error("entry count above capacity");

	a_scan_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> (ra_q != '0 && ra_q <= cnt_q))
		else $error("scan pointer out of range");

	a_shift_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |-> (CW'(w_q) + TWO_C <= cnt_q))
		else $error("shift pointer out of range");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_status == ST_FULL) |-> cnt_q == CAP_C)
		else $error("full refusal with room left");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_status == ST_EMPTY) |-> cnt_q == '0)
		else $error("empty refusal with entries stored");

endmodule

// ===== rtl/core/array_max_priority_queue_unit.sv =====
// channel | dir | handshake    | payload
// req     | in  | valid/ready  | action, value
// rsp     | out | valid/ready  | result_value, status, count
//
// Insert, refusals and the unused action code go straight from idle to the result state.
// Read makes one pass over the entries through the single memory read port.
// Remove then moves every entry behind the maximum down by one place.
// arst_n clears the sequencer, the entry count and the output valid; entries need no clearing.
// A finished result waits in the output register; a new item is taken while it waits.
module array_max_priority_queue_unit #(
	parameter int CAPACITY = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	ampq_req_if.sink          req,
	ampq_rsp_if.source        rsp
);
	import ampq_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic                       res_valid, res_ready;
	logic signed [VALUE_W-1:0]  res_value;
	status_t                    res_status;
	logic [CW-1:0]              res_count;

	logic                       mem_we, mem_re;
	logic [AW-1:0]              mem_waddr, mem_raddr;
	logic [VALUE_W-1:0]         mem_wdata, mem_rdata;

	scan_ctl_t                  scan_ctl;
	logic [AW-1:0]              scan_idx, scan_best_idx;
	logic signed [VALUE_W-1:0]  scan_best_val;

	logic                       out_valid_q;
	logic signed [VALUE_W-1:0]  out_value_q;
	logic [1:0]                 out_status_q;
	logic [COUNT_W-1:0]         out_count_q;

	ampq_ctrl #(
		.CAPACITY(CAPACITY),
		.AW(AW),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.req_action(req.action),
		.req_value(req.value),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_value(res_value),
		.res_status(res_status),
		.res_count(res_count),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.scan_ctl(scan_ctl),
		.scan_idx(scan_idx),
		.scan_best_val(scan_best_val),
		.scan_best_idx(scan_best_idx)
	);

	ampq_mem #(
		.DEPTH(CAPACITY),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	ampq_scan #(
		.AW(AW)
	) u_scan (
		.clk(clk),
		.ctl(scan_ctl),
		.data(mem_rdata),
		.idx(scan_idx),
		.best_val(scan_best_val),
		.best_idx(scan_best_idx)
	);

	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_value_q  <= res_value;
			out_status_q <= res_status;
			out_count_q  <= COUNT_W'(res_count);
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_value = out_value_q;
	assign rsp.status       = out_status_q;
	assign rsp.count        = out_count_q;

endmodule
